/* src/mps_pkg.sv */
// Shared types, constants and helpers of the maximin point selection block.
// No dependencies; mps_dist and the core import this package.
package mps_pkg;

   // Storage sizes.
   localparam int MaxPoints     = 256;
   localparam int IdxWidth      = $clog2(MaxPoints);
   localparam int CountWidth    = IdxWidth + 1;
   localparam int MaxObjectives = 4;
   localparam int ObjWidth      = 16;
   localparam int PointWidth    = ObjWidth * MaxObjectives;
   localparam int SqWidth       = 32;
   localparam int DistWidth     = 35;
   localparam int RunLimit      = 64;
   localparam int SelWidth      = 7;
   localparam int NobjWidth     = 3;
   localparam int CsrIdxWidth   = 1;
   localparam int CsrDataWidth  = 7;

   // Distance of a point that has not yet seen any chosen point.
   localparam logic [DistWidth-1:0] DistOnes = '1;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CsrSelectCount    = 1'b0;
   localparam logic [CsrIdxWidth-1:0] CsrObjectiveCount = 1'b1;

   typedef struct packed {
      logic signed [ObjWidth-1:0] obj_a;
      logic signed [ObjWidth-1:0] obj_b;
      logic signed [ObjWidth-1:0] obj_c;
      logic signed [ObjWidth-1:0] obj_d;
      logic                       last_point;
   } req_type;

   typedef struct packed {
      logic [IdxWidth-1:0] selected_index;
      logic                last_selected;
   } rsp_type;

   typedef enum logic [2:0] {
      StLoad,
      StStart,
      StScan,
      StPick,
      StAbsorb,
      StEmit
   } state_type;

   // One point handed to the distance pipeline.
   typedef struct packed {
      logic                valid;
      logic                skip;
      logic [IdxWidth-1:0] idx;
   } dist_req_type;

   // Write-back of an updated minimum distance.
   typedef struct packed {
      logic                 en;
      logic [IdxWidth-1:0]  idx;
      logic [DistWidth-1:0] data;
   } dist_wr_type;

   // Objective k of a packed point; objective 0 sits in the low bits.
   function automatic logic signed [ObjWidth-1:0] obj_field(
      input logic [PointWidth-1:0] point,
      input logic [1:0]            k
   );
      logic signed [ObjWidth-1:0] value;
      case (k)
         2'd0:    value = point[ObjWidth-1:0];
         2'd1:    value = point[2*ObjWidth-1:ObjWidth];
         2'd2:    value = point[3*ObjWidth-1:2*ObjWidth];
         default: value = point[4*ObjWidth-1:3*ObjWidth];
      endcase
      return value;
   endfunction

endpackage

/* src/mps_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mps_ram #(
   parameter int Width = 8,
   parameter int Depth = 16,
   parameter int AddrWidth = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mps_dist.sv */
// Two-stage squared distance pipeline that folds a new chosen point into the
// stored minimum distance of each point. Depends on mps_pkg.
module mps_dist (
   input  logic                             clock,
   input  logic                             reset,
   input  mps_pkg::dist_req_type            req,
   input  logic [mps_pkg::PointWidth-1:0]   point,
   input  logic [mps_pkg::PointWidth-1:0]   pick_point,
   input  logic [mps_pkg::NobjWidth-1:0]    nobj,
   input  logic [mps_pkg::DistWidth-1:0]    old_dist,
   output mps_pkg::dist_wr_type             wr,
   output logic                             busy
);
   import mps_pkg::*;

   logic                 v1_ff, v2_ff;
   logic                 skip1_ff, skip2_ff;
   logic [IdxWidth-1:0]  idx1_ff, idx2_ff;
   logic [DistWidth-1:0] old1_ff, old2_ff;
   logic [SqWidth-1:0]   sq_ff [MaxObjectives];
   logic [SqWidth-1:0]   sq_in [MaxObjectives];
   logic [DistWidth-1:0] sum2_ff;
   logic [DistWidth-1:0] sum_in;

   // Per-objective squared difference; unused objectives contribute zero.
   always_comb begin
      logic signed [ObjWidth-1:0]   obj_p;
      logic signed [ObjWidth-1:0]   obj_q;
      logic signed [ObjWidth:0]     diff;
      logic signed [2*ObjWidth+1:0] prod;
      for (int k = 0; k < MaxObjectives; k++) begin
         obj_p = obj_field(point, 2'(k));
         obj_q = obj_field(pick_point, 2'(k));
         diff = {obj_p[ObjWidth-1], obj_p} - {obj_q[ObjWidth-1], obj_q};
         prod = diff * diff;
         sq_in[k] = (NobjWidth'(k) < nobj) ? prod[SqWidth-1:0] : '0;
      end
   end

   // Sum of the registered squares.
   assign sum_in = DistWidth'(sq_ff[0]) + DistWidth'(sq_ff[1])
                 + DistWidth'(sq_ff[2]) + DistWidth'(sq_ff[3]);

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      skip1_ff <= req.skip;
      idx1_ff  <= req.idx;
      old1_ff  <= old_dist;
      sq_ff    <= sq_in;
      skip2_ff <= skip1_ff;
      idx2_ff  <= idx1_ff;
      old2_ff  <= old1_ff;
      sum2_ff  <= sum_in;
   end

   // Keep the smaller of the stored and the new distance.
   assign wr.en   = v2_ff && !skip2_ff;
   assign wr.idx  = idx2_ff;
   assign wr.data = (sum2_ff < old2_ff) ? sum2_ff : old2_ff;
   assign busy    = v1_ff || v2_ff;

endmodule

/* src/maximin_point_selection_core.sv */
// Maximin point selection core: loads points, then emits the selected indexes.
// Depends on mps_pkg, mps_ram and mps_dist.
//
// Points are taken one per cycle while the block is loading; the transfer
// that carries last_point starts a run, and no point is taken until the run
// has handed its last index to the result register. A run gives
// max(select_count, objective_count clamped to 1..4) indexes, at most 64.
// Each index takes one pass over the point memory and the distance memory to
// find the pick, then, for all but the last index, one pass to fold the pick
// into the stored minimum distance of every unchosen point, both bound by the
// single read port of each memory. Chosen and distance-valid flags live in
// flip-flops, so no clearing pass follows reset or starts a run.
module maximin_point_selection_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mps_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mps_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mps_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [mps_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import mps_pkg::*;

   state_type                  state_ff, state_in;
   logic [CountWidth-1:0]      point_count_ff, point_count_in;
   logic [SelWidth-1:0]        select_count_ff;
   logic [NobjWidth-1:0]       objective_count_ff;
   logic [NobjWidth-1:0]       nobj_ff, nobj_in;
   logic [SelWidth-1:0]        total_ff, total_in;
   logic [SelWidth-1:0]        round_ff, round_in;
   logic [CountWidth-1:0]      scan_idx_ff, scan_idx_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic [IdxWidth-1:0]        s1_idx_ff;
   logic                       found_ff, found_in;
   logic [IdxWidth-1:0]        best_idx_ff, best_idx_in;
   logic signed [ObjWidth-1:0] best_obj_ff, best_obj_in;
   logic [DistWidth-1:0]       best_dist_ff, best_dist_in;
   logic [PointWidth-1:0]      pick_point_ff, pick_point_in;
   logic [MaxPoints-1:0]       chosen_ff, chosen_in;
   logic [MaxPoints-1:0]       dist_valid_ff, dist_valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic                       req_xfer;
   logic                       issue;
   logic                       pt_wr_en;
   logic [PointWidth-1:0]      pt_wr_data;
   logic [PointWidth-1:0]      pt_rd;
   logic [DistWidth-1:0]       md_rd;
   logic [DistWidth-1:0]       cur_dist;
   logic signed [ObjWidth-1:0] cur_obj;
   logic                       obj_mode;
   logic                       last_round;
   logic                       better;
   logic                       dist_busy;
   dist_req_type               dist_req;
   dist_wr_type                dist_wr;

   // Handshake and read issue.
   assign req_ready = (state_ff == StLoad);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign issue     = ((state_ff == StScan) || (state_ff == StAbsorb))
                   && (scan_idx_ff < point_count_ff);

   // Point memory: written while loading, read during scan and fold passes.
   assign pt_wr_en   = req_xfer && (point_count_ff < CountWidth'(MaxPoints));
   assign pt_wr_data = {req_data.obj_d, req_data.obj_c, req_data.obj_b, req_data.obj_a};

   mps_ram #(
      .Width (PointWidth),
      .Depth (MaxPoints)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (point_count_ff[IdxWidth-1:0]),
      .wr_data (pt_wr_data),
      .rd_en   (issue),
      .rd_addr (scan_idx_ff[IdxWidth-1:0]),
      .rd_data (pt_rd)
   );

   // Minimum distance memory: written back by the distance pipeline.
   mps_ram #(
      .Width (DistWidth),
      .Depth (MaxPoints)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_wr.en),
      .wr_addr (dist_wr.idx),
      .wr_data (dist_wr.data),
      .rd_en   (issue),
      .rd_addr (scan_idx_ff[IdxWidth-1:0]),
      .rd_data (md_rd)
   );

   // Values of the point whose read data is present this cycle.
   assign cur_dist   = dist_valid_ff[s1_idx_ff] ? md_rd : DistOnes;
   assign cur_obj    = obj_field(pt_rd, round_ff[1:0]);
   assign obj_mode   = round_ff < SelWidth'(nobj_ff);
   assign last_round = (round_ff + SelWidth'(1)) == total_ff;
   assign better     = !found_ff || (obj_mode ? (cur_obj < best_obj_ff)
                                              : (cur_dist > best_dist_ff));

   // Distance pipeline feed during the fold pass.
   assign dist_req.valid = (state_ff == StAbsorb) && s1_valid_ff;
   assign dist_req.skip  = chosen_ff[s1_idx_ff];
   assign dist_req.idx   = s1_idx_ff;

   mps_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .req        (dist_req),
      .point      (pt_rd),
      .pick_point (pick_point_ff),
      .nobj       (nobj_ff),
      .old_dist   (cur_dist),
      .wr         (dist_wr),
      .busy       (dist_busy)
   );

   // Sequencer: next state and register updates.
   always_comb begin
      logic [SelWidth-1:0] run_len;
      state_in       = state_ff;
      point_count_in = point_count_ff;
      nobj_in        = nobj_ff;
      total_in       = total_ff;
      round_in       = round_ff;
      scan_idx_in    = scan_idx_ff;
      s1_valid_in    = issue;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_obj_in    = best_obj_ff;
      best_dist_in   = best_dist_ff;
      pick_point_in  = pick_point_ff;
      chosen_in      = chosen_ff;
      dist_valid_in  = dist_valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      run_len        = '0;

      if (dist_wr.en) begin
         dist_valid_in[dist_wr.idx] = 1'b1;
      end

      unique case (state_ff)
         StLoad: begin
            if (req_xfer) begin
               if (pt_wr_en) begin
                  point_count_in = point_count_ff + CountWidth'(1);
               end
               if (req_data.last_point) begin
                  state_in = StStart;
               end
            end
         end
         StStart: begin
            // Clamp the objective count and work out the run length.
            if (objective_count_ff == '0) begin
               nobj_in = NobjWidth'(1);
            end else if (objective_count_ff > NobjWidth'(MaxObjectives)) begin
               nobj_in = NobjWidth'(MaxObjectives);
            end else begin
               nobj_in = objective_count_ff;
            end
            run_len = (select_count_ff > SelWidth'(nobj_in)) ? select_count_ff
                                                              : SelWidth'(nobj_in);
            total_in      = (run_len > SelWidth'(RunLimit)) ? SelWidth'(RunLimit) : run_len;
            chosen_in     = '0;
            dist_valid_in = '0;
            round_in      = '0;
            scan_idx_in   = '0;
            found_in      = 1'b0;
            state_in      = StScan;
         end
         StScan: begin
            if (issue) begin
               scan_idx_in = scan_idx_ff + CountWidth'(1);
            end else if (!s1_valid_ff) begin
               state_in = StPick;
            end
            // Keep the best unchosen candidate, lowest index on ties.
            if (s1_valid_ff && !chosen_ff[s1_idx_ff] && better) begin
               found_in      = 1'b1;
               best_idx_in   = s1_idx_ff;
               best_obj_in   = cur_obj;
               best_dist_in  = cur_dist;
               pick_point_in = pt_rd;
            end
         end
         StPick: begin
            scan_idx_in = '0;
            if (found_ff) begin
               chosen_in[best_idx_ff] = 1'b1;
            end
            // The last pick needs no fold since no later pick reads it.
            if (found_ff && !last_round) begin
               state_in = StAbsorb;
            end else begin
               state_in = StEmit;
            end
         end
         StAbsorb: begin
            if (issue) begin
               scan_idx_in = scan_idx_ff + CountWidth'(1);
            end else if (!s1_valid_ff && !dist_busy) begin
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.selected_index = found_ff ? best_idx_ff : '0;
               rsp_data_in.last_selected  = last_round;
               round_in                   = round_ff + SelWidth'(1);
               found_in                   = 1'b0;
               scan_idx_in                = '0;
               if (last_round) begin
                  point_count_in = '0;
                  state_in       = StLoad;
               end else begin
                  state_in = StScan;
               end
            end
         end
         default: begin
            state_in = StLoad;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff     <= '0;
         select_count_ff    <= SelWidth'(8);
         objective_count_ff <= NobjWidth'(2);
         s1_valid_ff        <= 1'b0;
         found_ff           <= 1'b0;
         chosen_ff          <= '0;
         dist_valid_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
         round_ff           <= '0;
         scan_idx_ff        <= '0;
      end else begin
         point_count_ff <= point_count_in;
         s1_valid_ff    <= s1_valid_in;
         found_ff       <= found_in;
         chosen_ff      <= chosen_in;
         dist_valid_ff  <= dist_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         round_ff       <= round_in;
         scan_idx_ff    <= scan_idx_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CsrSelectCount:    select_count_ff    <= csr_wdata;
               CsrObjectiveCount: objective_count_ff <= csr_wdata[NobjWidth-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      nobj_ff       <= nobj_in;
      total_ff      <= total_in;
      s1_idx_ff     <= scan_idx_ff[IdxWidth-1:0];
      best_idx_ff   <= best_idx_in;
      best_obj_ff   <= best_obj_in;
      best_dist_ff  <= best_dist_in;
      pick_point_ff <= pick_point_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // The stored point count never passes the memory depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      point_count_ff <= CountWidth'(MaxPoints))
      else $error("point count beyond memory depth");

   // Distances are written back only during a fold pass.
   a_wr_in_absorb: assert property (@(posedge clock) disable iff (reset)
      dist_wr.en |-> (state_ff == StAbsorb))
      else $error("distance write outside fold pass");

   // A pick always names a point of the current set that was not chosen before.
   a_pick_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StPick && found_ff)
      |-> ({1'b0, best_idx_ff} < point_count_ff) && !chosen_ff[best_idx_ff])
      else $error("pick outside the point set or already chosen");

   // The final result of a run returns the block to loading with an empty set.
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StEmit && (!rsp_valid_ff || rsp_ready) && last_round)
      |=> (state_ff == StLoad) && (point_count_ff == '0) && rsp_valid_ff)
      else $error("run did not end cleanly");

endmodule
